// ----- rtl/poc_pkg.sv -----
// ----------------------------------------------------------------------------
// poc_pkg
// shared constants and types for the pattern occurrence counter
// ----------------------------------------------------------------------------
`default_nettype none

package poc_pkg;

  // widths fixed by the stream and register formats
  localparam int unsigned ByteW      = 8;
  localparam int unsigned LaneCount  = 8;
  localparam int unsigned PatternW   = ByteW * LaneCount;
  localparam int unsigned LengthW    = 4;
  localparam int unsigned CountW     = 32;
  localparam int unsigned ApbDataW   = 64;
  localparam int unsigned ApbAddrW   = 4;

  // design limit on the pattern length
  localparam int unsigned MaxPatternDefault = 8;

  localparam logic [CountW-1:0]  CountMax    = '1;
  localparam logic [LengthW-1:0] LengthReset = LengthW'(1);

  // register select, taken from paddr bit 3 (8-byte register spacing)
  typedef enum logic {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } reg_sel_t;

  typedef logic [LaneCount-1:0][ByteW-1:0] pattern_t;

  // per-byte decision handed from the matcher to the top level
  typedef struct packed {
    logic hit;
    logic keep_history;
  } match_status_t;

endpackage

`default_nettype wire

// ----- rtl/poc_matcher.sv -----
// ----------------------------------------------------------------------------
// poc_matcher
// compares the newest byte plus history against the pattern, builds next history
// ----------------------------------------------------------------------------
`default_nettype none

module poc_matcher
  import poc_pkg::*;
#(
  parameter  int unsigned MAX_PATTERN = MaxPatternDefault,
  localparam int unsigned EffMax      = (MAX_PATTERN < LaneCount) ? MAX_PATTERN : LaneCount,
  localparam int unsigned HistBytes   = (EffMax > 1) ? EffMax - 1 : 1,
  localparam int unsigned ValidW      = $clog2(HistBytes + 1)
) (
  input  wire logic [ByteW-1:0]                     data_byte,
  input  wire logic [HistBytes-1:0][ByteW-1:0]      history,
  input  wire logic [ValidW-1:0]                    history_valid,
  input  wire pattern_t                             pattern_bytes,
  input  wire logic [LengthW-1:0]                   pattern_length,
  output match_status_t                             status,
  output logic [HistBytes-1:0][ByteW-1:0]           history_shift,
  output logic [ValidW-1:0]                         valid_shift
);

  logic [LengthW-1:0]              len;
  logic [LengthW-1:0]              avail;
  logic [EffMax-1:0][ByteW-1:0]    ages;
  logic [LengthW-1:0]              pidx;
  logic                            all_eq;

  // clamp the configured length into 1..EffMax
  always_comb begin
    len = pattern_length;
    if (len == '0) begin
      len = LengthW'(1);
    end
    if (len > LengthW'(EffMax)) begin
      len = LengthW'(EffMax);
    end
  end

  assign avail = LengthW'(history_valid) + LengthW'(1);

  // age 0 is the new byte, age k is history byte k-1
  always_comb begin
    ages[0] = data_byte;
    for (int k = 1; k < EffMax; k++) begin
      ages[k] = history[k-1];
    end
  end

  always_comb begin
    all_eq = 1'b1;
    pidx   = '0;
    for (int k = 0; k < EffMax; k++) begin
      pidx = len - LengthW'(1) - LengthW'(k);
      if (LengthW'(k) < len) begin
        if (ages[k] != pattern_bytes[pidx[2:0]]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign status.hit          = (avail >= len) && all_eq;
  assign status.keep_history = !status.hit;

  // shifted history for the no-match case
  always_comb begin
    history_shift[0] = data_byte;
    for (int i = 1; i < HistBytes; i++) begin
      history_shift[i] = history[i-1];
    end
    if (avail > LengthW'(HistBytes)) begin
      valid_shift = ValidW'(HistBytes);
    end else begin
      valid_shift = avail[ValidW-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pattern_occurrence_counter.sv -----
// ----------------------------------------------------------------------------
// pattern_occurrence_counter
// counts non-overlapping occurrences of a 1..8 byte pattern in a byte stream
// ----------------------------------------------------------------------------
//
//   channel   dir   sync   contents
//   s_*       in    clk    data byte + end-of-file mark, one request per byte
//   m_*       out   clk    match flag, running count, file-done echo, one per byte
//   apb       in    clk    pattern bytes @0x0, pattern length @0x8, 64-bit data
//
// one byte per cycle unless the output stalls: the compare, history shift and count update are done
// in a single pass between the state registers and the output register
// output valid rises in the cycle after the input request is taken
// s_tready is high whenever the output register is empty or being drained,
// so a full output register stalls the input only while m_tready is low
// rst (synchronous) sets pattern length to 1, clears history, count, output valid and the pattern byte registers
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_occurrence_counter
  import poc_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPatternDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [ByteW-1:0]      s_tdata,   // [7:0] data_byte
  input  wire logic                  s_tlast,   // end_of_file
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [CountW-1:0]          m_tdata,   // [31:0] match_count
  output logic                       m_tuser,   // [0] match_here
  output logic                       m_tlast,   // file_done
  // register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ApbAddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]        prdata,
  output logic                       pready
);

  localparam int unsigned EffMax    = (MAX_PATTERN < LaneCount) ? MAX_PATTERN : LaneCount;
  localparam int unsigned HistBytes = (EffMax > 1) ? EffMax - 1 : 1;
  localparam int unsigned ValidW    = $clog2(HistBytes + 1);

  // configuration
  pattern_t                         pattern_bytes;
  logic [LengthW-1:0]               pattern_length;
  reg_sel_t                         reg_sel;
  logic                             cfg_write;

  // per-stream state
  logic [HistBytes-1:0][ByteW-1:0]  history;
  logic [ValidW-1:0]                history_valid;
  logic [CountW-1:0]                total;
  logic [CountW-1:0]                total_next;

  // matcher outputs
  match_status_t                    status;
  logic [HistBytes-1:0][ByteW-1:0]  history_shift;
  logic [ValidW-1:0]                valid_shift;

  logic                             in_take;

  // ---------------------------------------------------------------- apb
  assign pready    = 1'b1;
  assign reg_sel   = reg_sel_t'(paddr[3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      pattern_length <= LengthReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_PATTERN_BYTES:  pattern_bytes  <= pattern_t'(pwdata);
        REG_PATTERN_LENGTH: pattern_length <= pwdata[LengthW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PATTERN_BYTES:  prdata = ApbDataW'(pattern_bytes);
      REG_PATTERN_LENGTH: prdata = ApbDataW'(pattern_length);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- compare
  poc_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .data_byte      (s_tdata),
    .history        (history),
    .history_valid  (history_valid),
    .pattern_bytes  (pattern_bytes),
    .pattern_length (pattern_length),
    .status         (status),
    .history_shift  (history_shift),
    .valid_shift    (valid_shift)
  );

  // ---------------------------------------------------------------- state
  // output register drains or is empty -> room for the next byte
  assign s_tready = !m_tvalid || m_tready;
  assign in_take  = s_tvalid && s_tready;

  // saturating count
  assign total_next = (status.hit && (total != CountMax)) ? total + CountW'(1) : total;

  always_ff @(posedge clk) begin
    if (rst) begin
      history       <= '0;
      history_valid <= '0;
      total         <= '0;
    end else if (in_take) begin
      total <= total_next;
      // a match or an end of file wipes the history
      if (status.keep_history && !s_tlast) begin
        history       <= history_shift;
        history_valid <= valid_shift;
      end else begin
        history       <= '0;
        history_valid <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      m_tdata <= total_next;
      m_tuser <= status.hit;
      m_tlast <= s_tlast;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/poc_checker.sv -----
// ----------------------------------------------------------------------------
// poc_checker
// port-level checks on the result stream of the pattern occurrence counter
// ----------------------------------------------------------------------------
`default_nettype none

module poc_checker
  import poc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic [CountW-1:0]     m_tdata,
  input  wire logic                  m_tuser,
  input  wire logic                  m_tlast
);

  logic [CountW-1:0] last_count;
  logic              out_take;

  assign out_take = m_tvalid && m_tready;

  // count carried by the last delivered result, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (out_take) begin
      last_count <= m_tdata;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // no match, no change in the count
  a_no_match_steady: assert property (@(posedge clk) disable iff (rst)
    out_take && !m_tuser |-> m_tdata == last_count)
    else $error("count moved without a match");

  // a match adds one, or the count sits at its maximum
  a_match_step: assert property (@(posedge clk) disable iff (rst)
    out_take && m_tuser |-> (m_tdata == last_count + CountW'(1))
      || (last_count == CountMax && m_tdata == CountMax))
    else $error("match did not step the count by one");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind pattern_occurrence_counter poc_checker u_poc_checker (.*);

`default_nettype wire
